### rtl/energy_voice_activity_detector_core_defines.svh
// Assertion macros used by the voice activity detector sequencer.
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_CORE_DEFINES_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EVAD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("evad: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define EVAD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("evad: next-cycle check failed");

`endif

### rtl/evad_pkg.sv
// Shared widths, codes and control types of the voice activity detector.
package evad_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int TIME_W            = 48;
  localparam int CFG_W             = 16;
  localparam int CFG_IDX_W         = 2;
  localparam int SUM_W             = 43;
  localparam int COUNT_W           = 13;
  localparam int SQUARE_W          = 32;
  localparam int QUOT_W            = 31;
  localparam int RAD_W             = 32;
  localparam int REM_W             = 13;
  localparam int SQ_REM_W          = 18;
  localparam int RMS_W             = 16;
  localparam int STATE_W           = 2;
  localparam int LIMIT_US_W        = 27;
  localparam int STEP_W            = 6;
  localparam int MAX_CHUNK_SAMPLES = 4096;
  localparam int US_PER_MS         = 1000;

  localparam logic [STATE_W-1:0] DET_WAIT    = 2'd0;
  localparam logic [STATE_W-1:0] DET_SPEECH  = 2'd1;
  localparam logic [STATE_W-1:0] DET_SILENCE = 2'd2;
  localparam logic [STATE_W-1:0] DET_TIMEOUT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEECH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT    = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] speech_threshold;
    logic [CFG_W-1:0] initial_timeout_ms;
    logic [CFG_W-1:0] silence_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic session_reset;
    logic square;
    logic accumulate;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic time_prep;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic is_reset;
    logic last;
    logic out_full;
  } status_t;

endpackage

### rtl/evad_ctrl.sv
// Sequencer of the voice activity detector: accept, session reset or square and accumulate, divide, root, decide.
`include "energy_voice_activity_detector_core_defines.svh"

module evad_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  evad_pkg::status_t status,
  output evad_pkg::cmd_t    cmd
);
  import evad_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_ACC    = 4'd2;
  localparam logic [3:0] S_DINIT  = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_SINIT  = 4'd5;
  localparam logic [3:0] S_SQRT   = 4'd6;
  localparam logic [3:0] S_TIME   = 4'd7;
  localparam logic [3:0] S_DECIDE = 4'd8;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (status.is_reset) begin
          cmd.session_reset = 1'b1;
          state_next        = S_IDLE;
        end else begin
          cmd.square = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        state_next     = status.last ? S_DINIT : S_IDLE;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = STEP_W'(SUM_W - 1);
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_SINIT;
        end else begin
          cnt_next = cnt - STEP_W'(1);
        end
      end
      S_SINIT: begin
        cmd.sqrt_init = 1'b1;
        cnt_next      = STEP_W'(RMS_W - 1);
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_TIME;
        end else begin
          cnt_next = cnt - STEP_W'(1);
        end
      end
      S_TIME: begin
        cmd.time_prep = 1'b1;
        state_next    = S_DECIDE;
      end
      S_DECIDE: begin
        if (!status.out_full) begin
          cmd.decide = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `EVAD_ASSERT_NXT(a_accept_starts, clk, rst, in_valid && in_ready, state == S_MUL)
  `EVAD_ASSERT_NXT(a_reset_item_done, clk, rst, state == S_MUL && status.is_reset,
                   state == S_IDLE)
  `EVAD_ASSERT_NXT(a_div_to_sqrt, clk, rst, state == S_DIV && cnt == '0, state == S_SINIT)
  `EVAD_ASSERT_NXT(a_sqrt_to_time, clk, rst, state == S_SQRT && cnt == '0, state == S_TIME)
  `EVAD_ASSERT_NXT(a_hold_while_busy, clk, rst, state == S_DECIDE && status.out_full,
                   state == S_DECIDE)

endmodule

### rtl/evad_dp.sv
// Datapath of the voice activity detector: energy sum, divider, square root, detector.
module evad_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  evad_pkg::cmd_t                     cmd,
  output evad_pkg::status_t                  status,
  input  evad_pkg::cfg_t                     cfg,
  input  logic                               kind,
  input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
  input  logic                               last_in_chunk,
  input  logic [evad_pkg::TIME_W-1:0]        now_us,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [evad_pkg::STATE_W-1:0]       vad_state,
  output logic [evad_pkg::RMS_W-1:0]         chunk_rms,
  output logic                               chunk_is_speech
);
  import evad_pkg::*;

  // latched input beat
  logic                       kind_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;
  logic [TIME_W-1:0]          now_q;

  // model state
  logic [STATE_W-1:0] det;
  logic [TIME_W-1:0]  session_origin;
  logic [TIME_W-1:0]  speech_mark;
  logic [SUM_W-1:0]   square_sum;
  logic [COUNT_W-1:0] sample_count;

  // working registers
  logic [SQUARE_W-1:0]   square_q;
  logic [SUM_W-1:0]      div_q;
  logic [REM_W-1:0]      div_rem;
  logic [COUNT_W-1:0]    divisor;
  logic [RAD_W-1:0]      rad;
  logic [SQ_REM_W-1:0]   sq_rem;
  logic [RMS_W-1:0]      root;
  logic [RMS_W-1:0]      rms_q;
  logic                  speech_q;
  logic [TIME_W-1:0]     diff_q;
  logic [LIMIT_US_W-1:0] limit_us_q;

  logic [SAMPLE_W-1:0]   mag;
  logic [REM_W:0]        div_shift;
  logic                  div_fit;
  logic [SQ_REM_W+1:0]   sq_shift;
  logic [SQ_REM_W+1:0]   sq_trial;
  logic                  sq_fit;
  logic [CFG_W-1:0]      limit_ms;
  logic [LIMIT_US_W-1:0] limit_us;
  logic                  timed_out;

  assign mag       = sample_q[SAMPLE_W-1] ? SAMPLE_W'(~sample_q + SAMPLE_W'(1))
                                          : SAMPLE_W'(sample_q);
  assign div_shift = {div_rem, div_q[SUM_W-1]};
  assign div_fit   = div_shift >= {1'b0, divisor};
  assign sq_shift  = {sq_rem, rad[RAD_W-1 -: 2]};
  assign sq_trial  = (SQ_REM_W+2)'({root, 2'b01});
  assign sq_fit    = sq_shift >= sq_trial;
  assign limit_ms  = (det == DET_WAIT) ? cfg.initial_timeout_ms : cfg.silence_limit_ms;
  assign limit_us  = LIMIT_US_W'({1'b0, limit_ms} + (CFG_W+1)'(1))
                     * LIMIT_US_W'(US_PER_MS);
  assign timed_out = diff_q >= TIME_W'(limit_us_q);

  assign status.is_reset = kind_q;
  assign status.last     = last_q;
  assign status.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q   <= kind;
      sample_q <= sample;
      last_q   <= last_in_chunk;
      now_q    <= now_us;
    end
    if (cmd.square) begin
      square_q <= SQUARE_W'(mag) * SQUARE_W'(mag);
    end
    if (cmd.div_init) begin
      div_q   <= square_sum;
      div_rem <= '0;
      divisor <= (sample_count == '0) ? COUNT_W'(1) : sample_count;
    end else if (cmd.div_step) begin
      div_q   <= {div_q[SUM_W-2:0], div_fit};
      div_rem <= div_fit ? REM_W'(div_shift - {1'b0, divisor}) : REM_W'(div_shift);
    end
    if (cmd.sqrt_init) begin
      rad    <= RAD_W'(div_q[QUOT_W-1:0]);
      sq_rem <= '0;
      root   <= '0;
    end else if (cmd.sqrt_step) begin
      rad    <= {rad[RAD_W-3:0], 2'b00};
      sq_rem <= sq_fit ? SQ_REM_W'(sq_shift - sq_trial) : SQ_REM_W'(sq_shift);
      root   <= {root[RMS_W-2:0], sq_fit};
    end
    if (cmd.time_prep) begin
      rms_q      <= root;
      speech_q   <= root > cfg.speech_threshold;
      diff_q     <= now_q - ((det == DET_WAIT) ? session_origin : speech_mark);
      limit_us_q <= limit_us;
    end
    if (cmd.decide) begin
      chunk_rms       <= rms_q;
      chunk_is_speech <= speech_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      det            <= DET_WAIT;
      session_origin <= '0;
      speech_mark    <= '0;
      square_sum     <= '0;
      sample_count   <= '0;
      out_valid      <= 1'b0;
      vad_state      <= DET_WAIT;
    end else begin
      if (cmd.session_reset) begin
        det            <= DET_WAIT;
        session_origin <= now_q;
        speech_mark    <= '0;
        square_sum     <= '0;
        sample_count   <= '0;
      end else if (cmd.accumulate) begin
        if (sample_count < COUNT_W'(MAX_CHUNK_SAMPLES)) begin
          square_sum   <= square_sum + SUM_W'(square_q);
          sample_count <= sample_count + COUNT_W'(1);
        end
      end else if (cmd.div_init) begin
        square_sum   <= '0;
        sample_count <= '0;
      end
      if (cmd.decide) begin
        out_valid <= 1'b1;
        unique case (det)
          DET_WAIT: begin
            if (speech_q) begin
              det         <= DET_SPEECH;
              speech_mark <= now_q;
              vad_state   <= DET_SPEECH;
            end else if (timed_out) begin
              det       <= DET_TIMEOUT;
              vad_state <= DET_TIMEOUT;
            end else begin
              vad_state <= DET_WAIT;
            end
          end
          DET_SPEECH: begin
            if (speech_q) begin
              speech_mark <= now_q;
              vad_state   <= DET_SPEECH;
            end else if (timed_out) begin
              det       <= DET_SILENCE;
              vad_state <= DET_SILENCE;
            end else begin
              vad_state <= DET_SPEECH;
            end
          end
          default: begin
            vad_state <= det;
          end
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/energy_voice_activity_detector_core.sv
// Top level of the energy-based voice activity detector.
//
// Input channel (in_valid/in_ready): one beat per audio sample or session reset.
// A sample beat is squared and summed; a beat with last_in_chunk set closes
// the chunk and yields one result beat on the output channel
// (out_valid/out_ready) with the detector state, the chunk RMS and the speech
// flag. Session reset beats and non-final samples yield no result.
// Beats are taken one at a time, the next only once the block is idle: a
// sample is squared and summed, a reset clears the session, and a chunk-final
// beat also runs the 43-step restoring divider (sum over count) and the
// 16-step digit-by-digit square root, which share one sequencer.
// The output register holds the result until taken; new beats are accepted
// meanwhile, and only the next chunk end waits while the receiver stalls.
// Reset clears the detector to waiting, zeroes the session and speech times
// and the running sum, and loads the register defaults (threshold 500, initial
// timeout 5000 ms, silence limit 1500 ms). The user must write registers by
// cfg_we/cfg_index/cfg_data only while the block is idle; it is not enforced.
module energy_voice_activity_detector_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 kind,
  input  logic signed [evad_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 last_in_chunk,
  input  logic [evad_pkg::TIME_W-1:0]          now_us,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [evad_pkg::STATE_W-1:0]         vad_state,
  output logic [evad_pkg::RMS_W-1:0]           chunk_rms,
  output logic                                 chunk_is_speech,
  input  logic                                 cfg_we,
  input  logic [evad_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [evad_pkg::CFG_W-1:0]           cfg_data
);
  import evad_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speech_threshold   <= CFG_W'(500);
      cfg.initial_timeout_ms <= CFG_W'(5000);
      cfg.silence_limit_ms   <= CFG_W'(1500);
    end else if (cfg_we) begin
      priority case (cfg_index)
        CFG_SPEECH_THRESHOLD: cfg.speech_threshold   <= cfg_data;
        CFG_INITIAL_TIMEOUT:  cfg.initial_timeout_ms <= cfg_data;
        CFG_SILENCE_LIMIT:    cfg.silence_limit_ms   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  evad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  evad_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg             (cfg),
    .kind            (kind),
    .sample          (sample),
    .last_in_chunk   (last_in_chunk),
    .now_us          (now_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .vad_state       (vad_state),
    .chunk_rms       (chunk_rms),
    .chunk_is_speech (chunk_is_speech)
  );

endmodule

### tb/energy_voice_activity_detector_core_test.sv
// Self-checking testbench for the energy-based voice activity detector core.
`timescale 1ns / 1ps

module energy_voice_activity_detector_core_test;
  import evad_pkg::*;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_RESET  = 1'b1;
  localparam int   CYCLE_LIMIT = 4_000_000;
  localparam int   DRAIN_CYCLES = 80;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] smp;
    logic                last;
    logic [TIME_W-1:0]   stamp;
  } beat_t;

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [RMS_W-1:0]   rms;
    logic               speech;
  } verdict_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       kind = KIND_SAMPLE;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       last_in_chunk = 1'b0;
  logic [TIME_W-1:0]          now_us = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [STATE_W-1:0]         vad_state;
  logic [RMS_W-1:0]           chunk_rms;
  logic                       chunk_is_speech;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = CFG_SPEECH_THRESHOLD;
  logic [CFG_W-1:0]           cfg_data = '0;

  energy_voice_activity_detector_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .sample          (sample),
    .last_in_chunk   (last_in_chunk),
    .now_us          (now_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .vad_state       (vad_state),
    .chunk_rms       (chunk_rms),
    .chunk_is_speech (chunk_is_speech),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  beat_t             pending_beats[$];
  verdict_t          rms_verdict_q[$];
  cfg_t              cfg_copy;
  logic [STATE_W-1:0] det_state = DET_WAIT;
  logic [TIME_W-1:0] session_t0 = '0;
  logic [TIME_W-1:0] speech_t = '0;
  longint unsigned   energy_acc = 0;
  int unsigned       energy_n = 0;
  logic [TIME_W-1:0] wall_us = '0;

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  logic in_took = 1'b0;
  int queued_total = 0;
  int beats_taken = 0;
  int resets_taken = 0;
  int results_checked = 0;
  int speech_hits = 0;
  int state_hits[4] = '{0, 0, 0, 0};
  int fail_count = 0;
  int cycle_count = 0;
  verdict_t got_exp;

  function automatic logic [TIME_W-1:0] ms_since(input logic [TIME_W-1:0] now,
                                                 input logic [TIME_W-1:0] then);
    logic [TIME_W-1:0] d;
    d = now - then;
    return d / US_PER_MS;
  endfunction

  function automatic logic [RMS_W-1:0] floor_sqrt(input logic [31:0] v);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      c = r | (32'd1 << i);
      if (c * c <= v) r = c;
    end
    return r[RMS_W-1:0];
  endfunction

  function automatic void track_detector(input beat_t b);
    int s;
    logic [31:0] mean_sq;
    verdict_t v;
    if (b.kind == KIND_RESET) begin
      det_state = DET_WAIT;
      session_t0 = b.stamp;
      speech_t = '0;
      energy_acc = 0;
      energy_n = 0;
      resets_taken++;
    end else begin
      if (energy_n < MAX_CHUNK_SAMPLES) begin
        s = $signed(b.smp);
        if (s < 0) s = -s;
        energy_acc += longint'(s) * s;
        energy_n++;
      end
      if (b.last) begin
        mean_sq = energy_acc / ((energy_n == 0) ? 1 : energy_n);
        v.rms = floor_sqrt(mean_sq);
        v.speech = v.rms > cfg_copy.speech_threshold;
        case (det_state)
          DET_WAIT: begin
            if (v.speech) begin
              det_state = DET_SPEECH;
              speech_t = b.stamp;
            end else if (ms_since(b.stamp, session_t0) > cfg_copy.initial_timeout_ms) begin
              det_state = DET_TIMEOUT;
            end
          end
          DET_SPEECH: begin
            if (v.speech) begin
              speech_t = b.stamp;
            end else if (ms_since(b.stamp, speech_t) > cfg_copy.silence_limit_ms) begin
              det_state = DET_SILENCE;
            end
          end
          default: ;
        endcase
        v.state = det_state;
        energy_acc = 0;
        energy_n = 0;
        rms_verdict_q.push_back(v);
      end
    end
  endfunction

  // drive
  always @(negedge clk) begin : drive_in
    beat_t b;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        b = pending_beats.pop_front();
        in_valid <= 1'b1;
        kind <= b.kind;
        sample <= b.smp;
        last_in_chunk <= b.last;
        now_us <= b.stamp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (rms_verdict_q.size() == 0) begin
          $error("unexpected result beat: vad_state %0d chunk_rms %0d chunk_is_speech %0d",
                 vad_state, chunk_rms, chunk_is_speech);
          fail_count++;
        end else begin
          got_exp = rms_verdict_q.pop_front();
          if (vad_state !== got_exp.state) begin
            $error("vad_state: expected %0d, got %0d", got_exp.state, vad_state);
            fail_count++;
          end
          if (chunk_rms !== got_exp.rms) begin
            $error("chunk_rms: expected %0d, got %0d", got_exp.rms, chunk_rms);
            fail_count++;
          end
          if (chunk_is_speech !== got_exp.speech) begin
            $error("chunk_is_speech: expected %0d, got %0d", got_exp.speech, chunk_is_speech);
            fail_count++;
          end
          results_checked++;
          speech_hits += got_exp.speech;
          state_hits[got_exp.state]++;
        end
      end
      if (in_valid && in_ready) begin
        beats_taken++;
        track_detector({kind, sample, last_in_chunk, now_us});
      end
    end
  end

  function automatic logic [TIME_W-1:0] rand_stamp();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic void push_beat(input logic k, input logic [SAMPLE_W-1:0] s,
                                    input logic l, input logic [TIME_W-1:0] t);
    pending_beats.push_back({k, s, l, t});
    queued_total++;
  endfunction

  function automatic void push_reset(input logic [TIME_W-1:0] t);
    push_beat(KIND_RESET, SAMPLE_W'($urandom), 1'($urandom), t);
  endfunction

  // negative amp: fully random samples; else samples of magnitude amp, random sign
  function automatic void push_chunk(input int len, input int amp, input logic [TIME_W-1:0] t);
    logic [SAMPLE_W-1:0] s;
    for (int i = 0; i < len; i++) begin
      if (amp < 0) s = SAMPLE_W'($urandom);
      else s = $urandom_range(1) ? SAMPLE_W'(-amp) : SAMPLE_W'(amp);
      push_beat(KIND_SAMPLE, s, i == len - 1, (i == len - 1) ? t : rand_stamp());
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SPEECH_THRESHOLD: cfg_copy.speech_threshold = val;
      CFG_INITIAL_TIMEOUT:  cfg_copy.initial_timeout_ms = val;
      CFG_SILENCE_LIMIT:    cfg_copy.silence_limit_ms = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input int thr, input int tmo, input int sil);
    write_reg(CFG_SPEECH_THRESHOLD, CFG_W'(thr));
    write_reg(CFG_INITIAL_TIMEOUT, CFG_W'(tmo));
    write_reg(CFG_SILENCE_LIMIT, CFG_W'(sil));
  endtask

  task automatic settle();
    while (pending_beats.size() != 0 || in_valid) @(negedge clk);
    while (rms_verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void random_phase(input int n_beats, input int step_max);
    int stop_at;
    int roll;
    int thr;
    int amp;
    stop_at = queued_total + n_beats;
    thr = cfg_copy.speech_threshold;
    while (queued_total < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        wall_us += $urandom_range(step_max);
        push_reset(wall_us);
      end else if (roll < 9) begin
        for (int i = $urandom_range(3, 1); i > 0; i--)
          push_beat(KIND_SAMPLE, SAMPLE_W'($urandom), 1'b0, rand_stamp());
        push_reset(wall_us);
      end else begin
        if (roll < 12)
          wall_us = $urandom_range(1) ? rand_stamp() : wall_us - $urandom_range(step_max);
        else
          wall_us += $urandom_range(step_max);
        case ($urandom_range(3))
          0: amp = -1;
          1: amp = thr + int'($urandom_range(2)) - 1;
          2: amp = $urandom_range(thr);
          default: amp = $urandom_range(32768, thr);
        endcase
        if (amp > 32768) amp = 32768;
        push_chunk($urandom_range(8, 1), amp, wall_us);
      end
    end
  endfunction

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("energy_voice_activity_detector_core test failed");
    $finish;
  end

  initial begin
    cfg_copy.speech_threshold = 16'd500;
    cfg_copy.initial_timeout_ms = 16'd5000;
    cfg_copy.silence_limit_ms = 16'd1500;
    send_gap_pct = 29;
    recv_gap_pct = 47;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset defaults, threshold and timer boundaries, wrap, partial chunk discard
    push_chunk(2, 500, 48'd5_000_999);
    push_chunk(1, 501, 48'd5_001_000);
    push_chunk(1, 0, 48'd6_501_999);
    push_chunk(1, 32768, 48'd6_600_000);
    push_beat(KIND_SAMPLE, 16'h7FFF, 1'b0, rand_stamp());
    push_beat(KIND_SAMPLE, 16'h8000, 1'b1, 48'd7_000_000);
    push_chunk(2, 100, 48'd8_501_001);
    push_chunk(1, 32768, 48'd9_000_000);
    push_beat(KIND_SAMPLE, 16'd30000, 1'b0, rand_stamp());
    push_reset(48'hFFFF_FFFF_FC18);
    push_chunk(1, 10, 48'd4_999_999);
    push_chunk(1, 0, 48'd5_000_000);
    push_chunk(1, 20000, 48'd6_000_000);
    push_reset(48'd1_000_000);
    push_chunk(1, 0, 48'd0);
    settle();

    write_all(0, 0, 0);
    push_reset(48'd100);
    push_chunk(1, 0, 48'd1099);
    push_chunk(1, 0, 48'd1100);
    push_reset(48'd2000);
    push_chunk(1, 1, 48'd2000);
    push_chunk(1, 0, 48'd3000);
    settle();

    write_all(32768, 65535, 65535);
    push_reset(48'd0);
    push_chunk(1, 32768, 48'd65_535_999);
    push_chunk(1, 32768, 48'd65_536_000);
    settle();

    write_all($urandom_range(4000, 100), $urandom_range(30), $urandom_range(30));
    random_phase(275, 10_000);
    settle();

    send_gap_pct = 47;
    recv_gap_pct = 29;
    write_all($urandom_range(32768), 65535, 65535);
    random_phase(275, 80_000_000);
    settle();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_all($urandom_range(1000), 0, 0);
    random_phase(275, 3000);
    settle();

    if (rms_verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", rms_verdict_q.size());
      fail_count++;
    end
    $display("Run covered %0d beats (%0d session resets) and %0d chunk results, %0d speech.",
             beats_taken, resets_taken, results_checked, speech_hits);
    $display("Reported states: waiting %0d, speech %0d, silence %0d, timeout %0d.",
             state_hits[DET_WAIT], state_hits[DET_SPEECH], state_hits[DET_SILENCE],
             state_hits[DET_TIMEOUT]);
    if (fail_count == 0) begin
      $display("energy_voice_activity_detector_core test passed");
    end else begin
      $display("energy_voice_activity_detector_core test failed");
    end
    $finish;
  end

endmodule
